### sv/usan_pkg.sv
`timescale 1ns / 1ps

package usan_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] ASCII_MAX  = 8'h7f;
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD_E0    = 8'he0;
  localparam logic [7:0] LEAD_ED    = 8'hed;
  localparam logic [7:0] LEAD_F0    = 8'hf0;
  localparam logic [7:0] LEAD_F4    = 8'hf4;
  localparam logic [7:0] LIMIT_A0   = 8'ha0;
  localparam logic [7:0] LIMIT_90   = 8'h90;

  localparam logic [7:0] REPL_BYTE0 = 8'hef;
  localparam logic [7:0] REPL_BYTE1 = 8'hbf;
  localparam logic [7:0] REPL_BYTE2 = 8'hbd;

  localparam logic [1:0] REPL_LAST_SUB = 2'd2;

  // one queued action: a plain byte or a full replacement
  typedef struct packed {
    logic       repl;
    logic [7:0] value;
    logic       last;
  } action_t;

  typedef struct packed {
    logic    valid;
    action_t act;
  } qwr_t;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd0;
    if (lead >= LEAD2_LO && lead <= LEAD2_HI) len = 3'd2;
    else if (lead >= LEAD3_LO && lead <= LEAD3_HI) len = 3'd3;
    else if (lead >= LEAD4_LO && lead <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_CODE;
  endfunction

  function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] len);
    logic ok;
    ok = is_cont(b1);
    if (len >= 3'd3 && !is_cont(b2)) ok = 1'b0;
    if (len >= 3'd4 && !is_cont(b3)) ok = 1'b0;
    if (b0 == LEAD_E0 && b1 < LIMIT_A0) ok = 1'b0;
    if (b0 == LEAD_ED && b1 >= LIMIT_A0) ok = 1'b0;
    if (b0 == LEAD_F0 && b1 < LIMIT_90) ok = 1'b0;
    if (b0 == LEAD_F4 && b1 >= LIMIT_90) ok = 1'b0;
    return ok;
  endfunction

endpackage

### sv/utf8_stream_sanitizer.sv
`timescale 1ns / 1ps

// channel  | ports                 | transfer
// ---------+-----------------------+---------------------------
// input    | op, data_byte         | push && !full
// output   | out_byte, last        | pop && !empty
//
// a data byte is accepted, then scanned: the scan writes each byte it can
// decide to the action queue and closes before the next transfer is taken
// a flush also holds input off until its scan closes; a replacement leaves the output as 3 bytes
// the scan stalls while the action queue is full, the output holds until pop
// rst is synchronous; it clears held count, queue and output stage

module utf8_stream_sanitizer #(
  parameter int unsigned QUEUE_DEPTH = usan_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last
);

  usan_pkg::qwr_t    q_wr;
  logic              q_full;
  logic              q_empty;
  logic              rd_pop;
  usan_pkg::action_t head;

  usan_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .op        (op),
    .data_byte (data_byte),
    .full      (full),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  usan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .q_full  (q_full),
    .rd_pop  (rd_pop),
    .q_empty (q_empty),
    .head    (head)
  );

  usan_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .rd_pop   (rd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(q_wr.valid && q_full))
    else $error("action queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    !(rd_pop && q_empty))
    else $error("action queue read while empty");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("input accepted again before scan finished");

  a_repl_last_only_end : assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (out_byte != usan_pkg::REPL_BYTE0 ||
                          !u_back.cur.repl))
    else $error("last flag on first byte of a replacement");

endmodule

### sv/usan_front.sv
`timescale 1ns / 1ps

module usan_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 op,
  input  logic [7:0]           data_byte,
  output logic                 full,
  input  logic                 q_full,
  output usan_pkg::qwr_t       q_wr
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [7:0]        held [4];
  logic [7:0]        held_next [4];
  logic [2:0]        cnt, cnt_next;
  logic [1:0]        pass, pass_next;
  usan_pkg::action_t hold, hold_next;
  logic              hold_valid, hold_valid_next;

  logic [7:0] lead;
  logic [2:0] len;
  logic       ok;
  logic       done;
  logic       can_go;
  logic       accept;
  usan_pkg::action_t act;

  assign full   = (state != S_IDLE);
  assign accept = push && !full;
  assign lead   = held[0];
  assign len    = usan_pkg::seq_len(lead);
  assign ok     = usan_pkg::seq_ok(held[0], held[1], held[2], held[3], len);
  assign can_go = !hold_valid || !q_full;

  // end of scan: nothing left, or an unfinished sequence stays held
  assign done = (cnt == 3'd0) ||
                ((pass == 2'd0) && (lead > usan_pkg::ASCII_MAX) &&
                 (len != 3'd0) && (cnt < len));

  always_comb begin
    act.repl  = 1'b0;
    act.value = lead;
    act.last  = 1'b0;
    if (pass == 2'd0 && lead > usan_pkg::ASCII_MAX && (len == 3'd0 || !ok)) begin
      act.repl = 1'b1;
    end
  end

  always_comb begin
    q_wr.valid    = 1'b0;
    q_wr.act      = hold;
    q_wr.act.last = done;
    if (state == S_SCAN && hold_valid && !q_full) begin
      q_wr.valid = 1'b1;
    end
  end

  always_comb begin
    state_next      = state;
    held_next       = held;
    cnt_next        = cnt;
    pass_next       = pass;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
          pass_next  = 2'd0;
          if (op) begin
            cnt_next        = 3'd0;
            hold_next.repl  = 1'b1;
            hold_next.value = usan_pkg::REPL_BYTE0;
            hold_next.last  = 1'b0;
            hold_valid_next = (cnt != 3'd0);
          end else begin
            held_next[cnt[1:0]] = data_byte;
            cnt_next            = cnt + 3'd1;
            hold_valid_next     = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (can_go) begin
          if (done) begin
            state_next      = S_IDLE;
            hold_valid_next = 1'b0;
          end else begin
            hold_next       = act;
            hold_valid_next = 1'b1;
            held_next[0]    = held[1];
            held_next[1]    = held[2];
            held_next[2]    = held[3];
            cnt_next        = cnt - 3'd1;
            if (pass != 2'd0) begin
              pass_next = pass - 2'd1;
            end else if (!act.repl && lead > usan_pkg::ASCII_MAX) begin
              pass_next = 2'(len - 3'd1);
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= 3'd0;
      pass       <= 2'd0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pass       <= pass_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
    hold <= hold_next;
  end

endmodule

### sv/usan_queue.sv
`timescale 1ns / 1ps

module usan_queue #(
  parameter int unsigned DEPTH = usan_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  usan_pkg::qwr_t    wr,
  output logic              q_full,
  input  logic              rd_pop,
  output logic              q_empty,
  output usan_pkg::action_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  usan_pkg::action_t slots [DEPTH];
  logic [AW:0]       wr_ptr, rd_ptr;
  logic [AW:0]       level;

  assign level   = wr_ptr - rd_ptr;
  assign q_full  = (level == (AW + 1)'(DEPTH));
  assign q_empty = (level == '0);
  assign head    = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr.valid && !q_full) begin
        wr_ptr <= wr_ptr + (AW + 1)'(1);
      end
      if (rd_pop && !q_empty) begin
        rd_ptr <= rd_ptr + (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid && !q_full) begin
      slots[wr_ptr[AW-1:0]] <= wr.act;
    end
  end

endmodule

### sv/usan_back.sv
`timescale 1ns / 1ps

module usan_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  usan_pkg::action_t head,
  output logic              rd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              last
);

  usan_pkg::action_t cur;
  logic              cur_valid;
  logic [1:0]        sub;
  logic              take;
  logic              finish;
  logic              load;

  assign empty  = !cur_valid;
  assign take   = pop && cur_valid;
  assign finish = !cur.repl || (sub == usan_pkg::REPL_LAST_SUB);
  assign load   = !cur_valid || (take && finish);
  assign rd_pop = load && !q_empty;

  always_comb begin
    out_byte = cur.value;
    if (cur.repl) begin
      case (sub)
        2'd0:    out_byte = usan_pkg::REPL_BYTE0;
        2'd1:    out_byte = usan_pkg::REPL_BYTE1;
        default: out_byte = usan_pkg::REPL_BYTE2;
      endcase
    end
    last = cur.last && finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sub       <= 2'd0;
    end else if (load) begin
      cur_valid <= !q_empty;
      sub       <= 2'd0;
    end else if (take) begin
      sub <= sub + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic        OP_DATA       = 1'b0;
  localparam logic        OP_FLUSH      = 1'b1;
  localparam logic [7:0]  CONT_MAX      = usan_pkg::CONT_CODE | ~usan_pkg::CONT_MASK;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } out_beat_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic       op        = OP_DATA;
  logic [7:0] data_byte = 8'h00;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       last;

  out_beat_t   sanitized_q[$];
  out_beat_t   head;
  logic [7:0]  held_bytes[3];
  int unsigned held_count   = 0;
  int unsigned items_sent   = 0;
  int unsigned flushes_sent = 0;
  int unsigned bytes_out    = 0;
  int unsigned repl_count   = 0;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned pop_stall    = 0;
  bit          send_gaps_on = 1'b1;
  bit          pop_gaps_on  = 1'b1;

  utf8_stream_sanitizer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .data_byte (data_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last      (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d bytes still expected", $time,
               cycle_count, sanitized_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void add_replacement(ref logic [7:0] q[$]);
    q = {q, usan_pkg::REPL_BYTE0, usan_pkg::REPL_BYTE1, usan_pkg::REPL_BYTE2};
    repl_count++;
  endfunction

  task automatic predict_transfer(input logic op_i, input logic [7:0] byte_i);
    logic [7:0]  win[4];
    logic [7:0]  step_bytes[$];
    int unsigned total;
    int unsigned pos;
    int unsigned len;
    bit          ok;
    out_beat_t   beat;
    if (op_i == OP_FLUSH) begin
      if (held_count != 0) add_replacement(step_bytes);
      held_count = 0;
    end else begin
      for (int k = 0; k < held_count; k++) win[k] = held_bytes[k];
      win[held_count] = byte_i;
      total = held_count + 1;
      pos = 0;
      while (pos < total) begin
        if (win[pos] <= usan_pkg::ASCII_MAX) begin
          step_bytes = {step_bytes, win[pos]};
          pos++;
        end else begin
          len = 0;
          if (win[pos] >= usan_pkg::LEAD2_LO && win[pos] <= usan_pkg::LEAD2_HI) len = 2;
          else if (win[pos] >= usan_pkg::LEAD3_LO && win[pos] <= usan_pkg::LEAD3_HI) len = 3;
          else if (win[pos] >= usan_pkg::LEAD4_LO && win[pos] <= usan_pkg::LEAD4_HI) len = 4;
          if (len == 0) begin
            add_replacement(step_bytes);
            pos++;
          end else if (total - pos < len) begin
            break;
          end else begin
            ok = 1'b1;
            for (int k = 1; k < len; k++) begin
              if ((win[pos + k] & usan_pkg::CONT_MASK) != usan_pkg::CONT_CODE) ok = 1'b0;
            end
            if (win[pos] == usan_pkg::LEAD_E0 && win[pos + 1] < usan_pkg::LIMIT_A0) ok = 1'b0;
            if (win[pos] == usan_pkg::LEAD_ED && win[pos + 1] >= usan_pkg::LIMIT_A0) ok = 1'b0;
            if (win[pos] == usan_pkg::LEAD_F0 && win[pos + 1] < usan_pkg::LIMIT_90) ok = 1'b0;
            if (win[pos] == usan_pkg::LEAD_F4 && win[pos + 1] >= usan_pkg::LIMIT_90) ok = 1'b0;
            if (ok) begin
              for (int k = 0; k < len; k++) step_bytes = {step_bytes, win[pos + k]};
              pos += len;
            end else begin
              add_replacement(step_bytes);
              pos++;
            end
          end
        end
      end
      held_count = total - pos;
      for (int k = 0; k < held_count; k++) held_bytes[k] = win[pos + k];
    end
    foreach (step_bytes[i]) begin
      beat.value   = step_bytes[i];
      beat.is_last = (i == step_bytes.size() - 1);
      sanitized_q  = {sanitized_q, beat};
    end
  endtask

  // push is left high after a transfer so back-to-back items need no toggle
  task automatic send_item(input logic op_i, input logic [7:0] byte_i);
    int unsigned gap;
    gap = pick_gap(send_gaps_on);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    op        <= op_i;
    data_byte <= byte_i;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_transfer(op_i, byte_i);
    items_sent++;
    if (op_i == OP_FLUSH) flushes_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      bytes_out++;
      if (sanitized_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected none, actual byte %02h last %0b",
                 $time, out_byte, last);
      end else begin
        head = sanitized_q.pop_front();
        if (out_byte !== head.value || last !== head.is_last) begin
          errors++;
          $display("%0t: mismatch, expected byte %02h last %0b, actual byte %02h last %0b",
                   $time, head.value, head.is_last, out_byte, last);
        end
      end
    end
    if (pop_stall != 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      if (pop_gaps_on && $urandom_range(0, 3) == 0) pop_stall = pick_gap(1'b1);
    end
  end

  task automatic test_ascii_extremes();
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h7f);
  endtask

  task automatic test_valid_sequences();
    send_item(OP_DATA, 8'hc2);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'hf0);
    send_item(OP_DATA, 8'h90);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h80);
  endtask

  task automatic test_second_byte_limits();
    send_item(OP_DATA, 8'he0);
    send_item(OP_DATA, 8'h9f);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'hed);
    send_item(OP_DATA, 8'ha0);
    send_item(OP_DATA, 8'h80);
  endtask

  // every byte of a rejected four-byte sequence comes out as a replacement
  task automatic test_worst_burst_then_drain();
    send_item(OP_DATA, 8'hf4);
    send_item(OP_DATA, 8'h90);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h80);
    drain_results();
  endtask

  task automatic test_stray_leads();
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'hff);
  endtask

  task automatic test_flush();
    send_item(OP_DATA, 8'hc2);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_FLUSH, 8'hff);
  endtask

  task automatic send_codepoint(input bit damage);
    logic [7:0]  seq[4];
    int unsigned len;
    case ($urandom_range(0, 3))
      0: begin
        len = 1;
        seq[0] = 8'($urandom_range(0, usan_pkg::ASCII_MAX));
      end
      1: begin
        len = 2;
        seq[0] = 8'($urandom_range(usan_pkg::LEAD2_LO, usan_pkg::LEAD2_HI));
      end
      2: begin
        len = 3;
        seq[0] = 8'($urandom_range(usan_pkg::LEAD3_LO, usan_pkg::LEAD3_HI));
      end
      default: begin
        len = 4;
        seq[0] = 8'($urandom_range(usan_pkg::LEAD4_LO, usan_pkg::LEAD4_HI));
      end
    endcase
    for (int k = 1; k < len; k++) seq[k] = 8'($urandom_range(usan_pkg::CONT_CODE, CONT_MAX));
    if (seq[0] == usan_pkg::LEAD_E0)
      seq[1] = 8'($urandom_range(usan_pkg::LIMIT_A0, CONT_MAX));
    if (seq[0] == usan_pkg::LEAD_ED)
      seq[1] = 8'($urandom_range(usan_pkg::CONT_CODE, usan_pkg::LIMIT_A0 - 1));
    if (seq[0] == usan_pkg::LEAD_F0)
      seq[1] = 8'($urandom_range(usan_pkg::LIMIT_90, CONT_MAX));
    if (seq[0] == usan_pkg::LEAD_F4)
      seq[1] = 8'($urandom_range(usan_pkg::CONT_CODE, usan_pkg::LIMIT_90 - 1));
    if (damage) begin
      if (len > 1 && $urandom_range(0, 1) == 1) len = $urandom_range(1, len - 1);
      else seq[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < len; k++) send_item(OP_DATA, seq[k]);
  endtask

  task automatic test_random_stream(input int unsigned count, input bit send_gaps,
                                    input bit pop_gaps);
    int unsigned stop_at;
    int unsigned roll;
    send_gaps_on = send_gaps;
    pop_gaps_on  = pop_gaps;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) send_codepoint(1'b0);
      else if (roll < 90) send_codepoint(1'b1);
      else if (roll < 97) send_item(OP_DATA, 8'($urandom_range(0, 255)));
      else send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
    end
    send_gaps_on = 1'b1;
    pop_gaps_on  = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_ascii_extremes();
    test_valid_sequences();
    test_second_byte_limits();
    test_worst_burst_then_drain();
    test_stray_leads();
    test_flush();
    test_random_stream(140, 1'b1, 1'b1);
    test_random_stream(110, 1'b0, 1'b0);
    test_random_stream(100, 1'b1, 1'b0);
    drain_results();
    $display("stream of %0d transfers in (%0d flushes), %0d bytes out", items_sent,
             flushes_sent, bytes_out);
    $display("valid, truncated, corrupted and stray sequences; %0d replacements",
             repl_count);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
sv/usan_pkg.sv
sv/usan_front.sv
sv/usan_queue.sv
sv/usan_back.sv
sv/utf8_stream_sanitizer.sv
tb/tb_top.sv
